@@ rtl/m3hs_pkg.sv @@
// shared constants, widths, types and tables of the masked 3x3 height smoother
// depends on nothing; imported by every module under rtl
package m3hs_pkg;

    // sample format
    localparam int HEIGHT_BITS = 24;
    localparam int NB_COUNT    = 8;

    // derived datapath widths
    localparam int DIFF_W = HEIGHT_BITS + 1;   // neighbor minus center
    localparam int SUM_W  = HEIGHT_BITS + 5;   // weighted sum of differences
    localparam int MAG_W  = HEIGHT_BITS + 4;   // magnitude of the weighted sum
    localparam int WGT_W  = 5;                 // total tap weight, 1..16
    localparam int RES_W  = MAG_W + 2;         // center plus signed correction

    // blend factor, unsigned q1.10
    localparam int                BLEND_BITS  = 11;
    localparam int                BLEND_SHIFT = 10;
    localparam logic [BLEND_BITS-1:0] BLEND_ONE = BLEND_BITS'(1 << BLEND_SHIFT);
    localparam int PROD_W = MAG_W + BLEND_BITS;
    localparam int M_W    = PROD_W + 1;

    // reciprocal of the tap weight, scaled by 2^MAG_W
    localparam int    RECIP_W   = MAG_W + 1;
    localparam longint RECIP_ONE = 64'sd1 <<< MAG_W;
    localparam logic [RECIP_W-1:0] RECIP_TAB [0:15] = '{
        RECIP_W'(RECIP_ONE / 1),  RECIP_W'(RECIP_ONE / 2),
        RECIP_W'(RECIP_ONE / 3),  RECIP_W'(RECIP_ONE / 4),
        RECIP_W'(RECIP_ONE / 5),  RECIP_W'(RECIP_ONE / 6),
        RECIP_W'(RECIP_ONE / 7),  RECIP_W'(RECIP_ONE / 8),
        RECIP_W'(RECIP_ONE / 9),  RECIP_W'(RECIP_ONE / 10),
        RECIP_W'(RECIP_ONE / 11), RECIP_W'(RECIP_ONE / 12),
        RECIP_W'(RECIP_ONE / 13), RECIP_W'(RECIP_ONE / 14),
        RECIP_W'(RECIP_ONE / 15), RECIP_W'(RECIP_ONE / 16)
    };

    // saturation bounds in the wide result format
    localparam logic signed [RES_W-1:0] HMAX = RES_W'((64'sd1 <<< (HEIGHT_BITS - 1)) - 1);
    localparam logic signed [RES_W-1:0] HMIN = RES_W'(-(64'sd1 <<< (HEIGHT_BITS - 1)));

    // configuration register indexes and mode codes
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_BLEND  = 1'b1;
    localparam logic MODE_EQUAL = 1'b0;
    localparam logic MODE_GAUSS = 1'b1;

    localparam logic [WGT_W-1:0] CENTER_WGT_EQUAL = WGT_W'(1);
    localparam logic [WGT_W-1:0] CENTER_WGT_GAUSS = WGT_W'(4);

    // control of the two divider stages
    typedef struct packed {
        logic en_mul;   // load enable of the reciprocal multiply stage
        logic en_fix;   // load enable of the correction stage
        logic vld_in;   // beat present at the divider input
        logic vld_mul;  // beat held in the reciprocal multiply stage
    } t_div_ctl;

    // 1-2-1 kernel weight of neighbor nw,n,ne,w,e,sw,s,se
    function automatic logic [1:0] gauss_weight(input logic [2:0] idx);
        logic [1:0] w;
        case (idx)
            3'd1, 3'd3, 3'd4, 3'd6: w = 2'd2;
            default:                w = 2'd1;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/masked_3x3_height_smoother.sv @@
// top level of the masked 3x3 height smoother: eight-stage beat pipeline
// uses m3hs_pkg and m3hs_div
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+---------------------------------------------
//  window    | in        | i_valid / o_stall  | center, eight neighbors, masks
//  result    | out       | o_valid / i_stall  | o_smoothed_height, o_result_valid
//  config    | in        | i_cfg_we           | i_cfg_idx, i_cfg_wdata
//
// one beat enters per clock while o_stall is low
// the eight register stages are: weighted differences, two adder levels,
// blend multiply, rounding offset, reciprocal multiply, correction, final add
// a stall holds the output register; bubbles inside the pipe still close up,
// so o_stall rises only when all eight stages hold a beat
// synchronous active-low reset empties the pipe, mode 0 and full blend
module masked_3x3_height_smoother (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [m3hs_pkg::BLEND_BITS-1:0]       i_cfg_wdata,
    // window channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [m3hs_pkg::HEIGHT_BITS-1:0] i_center_height,
    input  logic signed [m3hs_pkg::HEIGHT_BITS-1:0] i_nw_height,
    input  logic signed [m3hs_pkg::HEIGHT_BITS-1:0] i_n_height,
    input  logic signed [m3hs_pkg::HEIGHT_BITS-1:0] i_ne_height,
    input  logic signed [m3hs_pkg::HEIGHT_BITS-1:0] i_w_height,
    input  logic signed [m3hs_pkg::HEIGHT_BITS-1:0] i_e_height,
    input  logic signed [m3hs_pkg::HEIGHT_BITS-1:0] i_sw_height,
    input  logic signed [m3hs_pkg::HEIGHT_BITS-1:0] i_s_height,
    input  logic signed [m3hs_pkg::HEIGHT_BITS-1:0] i_se_height,
    input  logic [7:0]                            i_neighbour_valid,
    input  logic                                  i_center_valid,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [m3hs_pkg::HEIGHT_BITS-1:0] o_smoothed_height,
    output logic                                  o_result_valid
);
    import m3hs_pkg::*;

    localparam int NS = 8;

    // configuration registers
    logic                  r_mode;
    logic [BLEND_BITS-1:0] r_blend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_EQUAL;
            r_blend <= BLEND_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:  r_mode  <= i_cfg_wdata[0];
                REG_BLEND: r_blend <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage occupancy and load enables; a stage loads when empty or draining
    logic [NS:1] r_vld;
    logic [NS:1] en;

    always_comb begin
        en[NS] = !r_vld[NS] || !i_stall;
        for (int k = NS - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: masked, weighted differences to the center
    logic signed [HEIGHT_BITS-1:0] s1_nb   [NB_COUNT];
    logic signed [DIFF_W-1:0]      s1_diff [NB_COUNT];
    logic signed [SUM_W-1:0]       s1_wd   [NB_COUNT];
    logic [WGT_W-1:0]              s1_w;
    logic [BLEND_BITS-1:0]         s1_a;

    logic signed [SUM_W-1:0]       r1_wd   [NB_COUNT];
    logic [WGT_W-1:0]              r1_w;
    logic [BLEND_BITS-1:0]         r1_a;
    logic signed [HEIGHT_BITS-1:0] r1_h;
    logic                          r1_cv;

    assign s1_nb[0] = i_nw_height;
    assign s1_nb[1] = i_n_height;
    assign s1_nb[2] = i_ne_height;
    assign s1_nb[3] = i_w_height;
    assign s1_nb[4] = i_e_height;
    assign s1_nb[5] = i_sw_height;
    assign s1_nb[6] = i_s_height;
    assign s1_nb[7] = i_se_height;

    // sum of weights times (neighbor - center) equals the weighted sum minus center times weight
    always_comb begin
        s1_w = (r_mode == MODE_GAUSS) ? CENTER_WGT_GAUSS : CENTER_WGT_EQUAL;
        for (int i = 0; i < NB_COUNT; i++) begin
            s1_diff[i] = DIFF_W'(s1_nb[i]) - DIFF_W'(i_center_height);
            if (!i_neighbour_valid[i]) begin
                s1_wd[i] = '0;
            end else if (r_mode == MODE_GAUSS && gauss_weight(3'(i)) == 2'd2) begin
                s1_wd[i] = SUM_W'(s1_diff[i]) <<< 1;
            end else begin
                s1_wd[i] = SUM_W'(s1_diff[i]);
            end
            if (i_neighbour_valid[i]) begin
                s1_w = s1_w + ((r_mode == MODE_GAUSS) ? WGT_W'(gauss_weight(3'(i)))
                                                      : WGT_W'(1));
            end
        end
        // blend amounts above one act as full smoothing
        s1_a = (r_blend > BLEND_ONE) ? BLEND_ONE : r_blend;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_wd <= s1_wd;
            r1_w  <= s1_w;
            r1_a  <= s1_a;
            r1_h  <= i_center_height;
            r1_cv <= i_center_valid;
        end
    end

    // ---------------- stage 2: two partial sums of four
    logic signed [SUM_W-1:0]       r2_p0;
    logic signed [SUM_W-1:0]       r2_p1;
    logic [WGT_W-1:0]              r2_w;
    logic [BLEND_BITS-1:0]         r2_a;
    logic signed [HEIGHT_BITS-1:0] r2_h;
    logic                          r2_cv;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_p0 <= (r1_wd[0] + r1_wd[1]) + (r1_wd[2] + r1_wd[3]);
            r2_p1 <= (r1_wd[4] + r1_wd[5]) + (r1_wd[6] + r1_wd[7]);
            r2_w  <= r1_w;
            r2_a  <= r1_a;
            r2_h  <= r1_h;
            r2_cv <= r1_cv;
        end
    end

    // ---------------- stage 3: total deviation
    logic signed [SUM_W-1:0]       r3_d;
    logic [WGT_W-1:0]              r3_w;
    logic [BLEND_BITS-1:0]         r3_a;
    logic signed [HEIGHT_BITS-1:0] r3_h;
    logic                          r3_cv;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_d  <= r2_p0 + r2_p1;
            r3_w  <= r2_w;
            r3_a  <= r2_a;
            r3_h  <= r2_h;
            r3_cv <= r2_cv;
        end
    end

    // ---------------- stage 4: magnitude times blend amount
    logic signed [SUM_W-1:0]       s4_neg_d;
    logic [MAG_W-1:0]              s4_mag;
    logic [PROD_W-1:0]             r4_prod;
    logic                          r4_neg;
    logic [WGT_W-1:0]              r4_w;
    logic signed [HEIGHT_BITS-1:0] r4_h;
    logic                          r4_cv;

    always_comb begin
        s4_neg_d = -r3_d;
        s4_mag   = r3_d[SUM_W-1] ? s4_neg_d[MAG_W-1:0] : r3_d[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_prod <= PROD_W'(s4_mag) * PROD_W'(r3_a);
            r4_neg  <= r3_d[SUM_W-1];
            r4_w    <= r3_w;
            r4_h    <= r3_h;
            r4_cv   <= r3_cv;
        end
    end

    // ---------------- stage 5: add half the divisor, drop the q1.10 scale
    logic [M_W-1:0]                s5_m;
    logic [MAG_W-1:0]              r5_mq;
    logic                          r5_neg;
    logic [WGT_W-1:0]              r5_w;
    logic signed [HEIGHT_BITS-1:0] r5_h;
    logic                          r5_cv;

    // floor((m) / (w * 1024)) equals floor(floor(m / 1024) / w)
    always_comb begin
        s5_m = M_W'(r4_prod) + (M_W'(r4_w) << (BLEND_SHIFT - 1));
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_mq  <= s5_m[MAG_W+BLEND_SHIFT-1:BLEND_SHIFT];
            r5_neg <= r4_neg;
            r5_w   <= r4_w;
            r5_h   <= r4_h;
            r5_cv  <= r4_cv;
        end
    end

    // ---------------- stages 6 and 7: divide by the tap weight
    t_div_ctl                      div_ctl;
    logic [MAG_W-1:0]              div_q;
    logic                          r6_neg;
    logic signed [HEIGHT_BITS-1:0] r6_h;
    logic                          r6_cv;
    logic                          r7_neg;
    logic signed [HEIGHT_BITS-1:0] r7_h;
    logic                          r7_cv;

    assign div_ctl.en_mul  = en[6];
    assign div_ctl.en_fix  = en[7];
    assign div_ctl.vld_in  = r_vld[5];
    assign div_ctl.vld_mul = r_vld[6];

    m3hs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_mq    (r5_mq),
        .i_w     (r5_w),
        .o_q     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_neg <= r5_neg;
            r6_h   <= r5_h;
            r6_cv  <= r5_cv;
        end
        if (en[7]) begin
            r7_neg <= r6_neg;
            r7_h   <= r6_h;
            r7_cv  <= r6_cv;
        end
    end

    // ---------------- stage 8: apply the correction, saturate, output register
    logic signed [RES_W-1:0]       s8_qpos;
    logic signed [RES_W-1:0]       s8_qs;
    logic signed [RES_W-1:0]       s8_r;
    logic signed [HEIGHT_BITS-1:0] n_height;
    logic signed [HEIGHT_BITS-1:0] r_height;
    logic                          r_res_vld;

    always_comb begin
        s8_qpos = RES_W'(div_q);
        s8_qs   = r7_neg ? -s8_qpos : s8_qpos;
        s8_r    = RES_W'(r7_h) + s8_qs;
        if (!r7_cv) begin
            // invalid center passes through untouched
            n_height = r7_h;
        end else if (s8_r > HMAX) begin
            n_height = HMAX[HEIGHT_BITS-1:0];
        end else if (s8_r < HMIN) begin
            n_height = HMIN[HEIGHT_BITS-1:0];
        end else begin
            n_height = s8_r[HEIGHT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_height  <= n_height;
            r_res_vld <= r7_cv;
        end
    end

    assign o_valid           = r_vld[NS];
    assign o_smoothed_height = r_height;
    assign o_result_valid    = r_res_vld;

    a_full_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled while a pipeline stage is empty");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r1_w >= CENTER_WGT_EQUAL && r1_w <= WGT_W'(16)
                      && (r_mode != MODE_GAUSS || r1_w >= CENTER_WGT_GAUSS)))
        else $error("tap weight total out of range");

    a_blend_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r1_a <= BLEND_ONE))
        else $error("blend amount not clamped to one");

endmodule

@@ rtl/m3hs_div.sv @@
// two-stage exact floor division of a rounded magnitude by the tap weight
// reciprocal multiply then one correction step; depends on m3hs_pkg
module m3hs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  m3hs_pkg::t_div_ctl            i_ctl,
    input  logic [m3hs_pkg::MAG_W-1:0]    i_mq,
    input  logic [m3hs_pkg::WGT_W-1:0]    i_w,
    output logic [m3hs_pkg::MAG_W-1:0]    o_q
);
    import m3hs_pkg::*;

    logic [MAG_W+RECIP_W-1:0] s_prod;
    logic [MAG_W-1:0]         r_q0;
    logic [MAG_W-1:0]         r_mq;
    logic [WGT_W-1:0]         r_w;
    logic [MAG_W-1:0]         s_rem;
    logic [MAG_W-1:0]         r_q;
    logic [MAG_W-1:0]         n_q;

    // estimate is either the quotient or one below
    always_comb begin
        s_prod = (MAG_W+RECIP_W)'(i_mq) * (MAG_W+RECIP_W)'(RECIP_TAB[4'(i_w - WGT_W'(1))]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_q0 <= s_prod[2*MAG_W-1:MAG_W];
            r_mq <= i_mq;
            r_w  <= i_w;
        end
    end

    always_comb begin
        s_rem = r_mq - MAG_W'(r_q0 * MAG_W'(r_w));
        n_q   = (s_rem >= MAG_W'(r_w)) ? r_q0 + MAG_W'(1) : r_q0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_fix) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

    a_w_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.vld_in |-> (i_w != '0))
        else $error("divider fed a zero tap weight");

    a_est_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.vld_mul |-> (r_q0 <= r_mq))
        else $error("reciprocal estimate above dividend");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.vld_mul |-> ({1'b0, s_rem} < ({1'b0, MAG_W'(r_w)} << 1)))
        else $error("reciprocal estimate off by more than one");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench of masked_3x3_height_smoother: directed and random windows
// depends on m3hs_pkg and the rtl top level; predicts each result and checks it

module tb_top;
    import m3hs_pkg::*;

    localparam int H            = HEIGHT_BITS;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 12;   // pipe is eight stages deep
    localparam int SEGMENTS     = 8;
    localparam int SEG_BEATS    = 150;

    // taps on the edges of the window carry weight 2 in the 1-2-1 kernel
    localparam logic [7:0] EDGE_TAPS = 8'b0101_1010;

    localparam logic signed [H-1:0] H_MAX = {1'b0, {(H-1){1'b1}}};
    localparam logic signed [H-1:0] H_MIN = {1'b1, {(H-1){1'b0}}};

    // sender idle and receiver stall percentages per pressure phase
    localparam int IDLE_PCT [4]  = '{0, 64, 0, 6};
    localparam int STALL_PCT [4] = '{0, 0, 64, 6};

    typedef struct packed {
        logic signed [H-1:0] center;
        logic [7:0][H-1:0]   nb;      // nw, n, ne, w, e, sw, s, se
        logic [7:0]          mask;
        logic                cvalid;
    } t_window;

    typedef struct packed {
        logic signed [H-1:0] height;
        logic                vld;
    } t_smooth_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_idx = REG_MODE;
    logic [BLEND_BITS-1:0] i_cfg_wdata = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic signed [H-1:0]   i_center_height = '0;
    logic signed [H-1:0]   i_nw_height = '0;
    logic signed [H-1:0]   i_n_height = '0;
    logic signed [H-1:0]   i_ne_height = '0;
    logic signed [H-1:0]   i_w_height = '0;
    logic signed [H-1:0]   i_e_height = '0;
    logic signed [H-1:0]   i_sw_height = '0;
    logic signed [H-1:0]   i_s_height = '0;
    logic signed [H-1:0]   i_se_height = '0;
    logic [7:0]            i_neighbour_valid = '0;
    logic                  i_center_valid = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic signed [H-1:0]   o_smoothed_height;
    logic                  o_result_valid;

    // local copy of the two registers
    logic                  cur_mode = MODE_EQUAL;
    logic [BLEND_BITS-1:0] cur_blend = BLEND_ONE;

    t_smooth_res pending_results [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;

    masked_3x3_height_smoother uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_center_height   (i_center_height),
        .i_nw_height       (i_nw_height),
        .i_n_height        (i_n_height),
        .i_ne_height       (i_ne_height),
        .i_w_height        (i_w_height),
        .i_e_height        (i_e_height),
        .i_sw_height       (i_sw_height),
        .i_s_height        (i_s_height),
        .i_se_height       (i_se_height),
        .i_neighbour_valid (i_neighbour_valid),
        .i_center_valid    (i_center_valid),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_smoothed_height (o_smoothed_height),
        .o_result_valid    (o_result_valid)
    );

    always #10 i_clk = ~i_clk;

    // run limit, far above the slowest correct run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // weighted average over valid taps, blended toward it from the center,
    // one rounding (half away from zero) and saturation to the height range
    function automatic t_smooth_res predict_smoothed(t_window w, logic mode,
                                                     logic [BLEND_BITS-1:0] blend);
        t_smooth_res r;
        longint      h, acc, wt, tap_w, amt, num, den, mag, q, y;
        r.vld    = w.cvalid;
        r.height = w.center;
        if (!w.cvalid)
            return r;
        h   = w.center;
        wt  = (mode == MODE_GAUSS) ? 4 : 1;
        acc = h * wt;
        for (int i = 0; i < 8; i++) begin
            if (w.mask[i]) begin
                tap_w = (mode == MODE_GAUSS && EDGE_TAPS[i]) ? 2 : 1;
                acc   = acc + longint'($signed(w.nb[i])) * tap_w;
                wt    = wt + tap_w;
            end
        end
        amt = (blend > BLEND_ONE) ? longint'(BLEND_ONE) : longint'(blend);
        num = (acc - h * wt) * amt;
        den = wt * longint'(BLEND_ONE);
        mag = (num < 0) ? -num : num;
        q   = (mag + den / 2) / den;
        if (num < 0)
            q = -q;
        y = h + q;
        if (y > longint'(H_MAX))
            y = H_MAX;
        if (y < longint'(H_MIN))
            y = H_MIN;
        r.height = y[H-1:0];
        return r;
    endfunction

    // result side: check every accepted beat, then pick the next stall
    always @(posedge i_clk) begin
        t_smooth_res want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with nothing expected, actual %0d valid %0b",
                             $time, o_smoothed_height, o_result_valid);
                end else begin
                    want = pending_results.pop_front();
                    if (o_smoothed_height !== want.height) begin
                        fail_count++;
                        $display("%0t: smoothed_height expected %0d actual %0d",
                                 $time, want.height, o_smoothed_height);
                    end
                    if (o_result_valid !== want.vld) begin
                        fail_count++;
                        $display("%0t: result_valid expected %0b actual %0b",
                                 $time, want.vld, o_result_valid);
                    end
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // offer one window, with random idle cycles in front, and wait for acceptance
    task automatic send_window(input t_window w);
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_center_height   <= w.center;
        i_nw_height       <= w.nb[0];
        i_n_height        <= w.nb[1];
        i_ne_height       <= w.nb[2];
        i_w_height        <= w.nb[3];
        i_e_height        <= w.nb[4];
        i_sw_height       <= w.nb[5];
        i_s_height        <= w.nb[6];
        i_se_height       <= w.nb[7];
        i_neighbour_valid <= w.mask;
        i_center_valid    <= w.cvalid;
        i_valid           <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(predict_smoothed(w, cur_mode, cur_blend));
    endtask

    // stop offering and let every outstanding result come out
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // both registers are written back to back, only with the pipe empty
    task automatic set_config(input logic mode, input logic [BLEND_BITS-1:0] blend);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_MODE;
        i_cfg_wdata <= BLEND_BITS'(mode);
        @(posedge i_clk);
        i_cfg_idx   <= REG_BLEND;
        i_cfg_wdata <= blend;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_mode    = mode;
        cur_blend   = blend;
    endtask

    function automatic t_window flat_window(logic signed [H-1:0] c, logic signed [H-1:0] nbv,
                                            logic [7:0] mask, logic cvalid);
        t_window w;
        w.center = c;
        for (int i = 0; i < 8; i++)
            w.nb[i] = nbv;
        w.mask   = mask;
        w.cvalid = cvalid;
        return w;
    endfunction

    // terrain-like heights: mostly close to a base, some raw and some extreme
    function automatic logic signed [H-1:0] pick_height(logic signed [H-1:0] base);
        case ($urandom_range(5))
            0:       return H'($urandom);
            1: begin
                case ($urandom_range(3))
                    0:       return H_MAX;
                    1:       return H_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return base + H'($urandom_range(8191)) - H'(4096);
        endcase
    endfunction

    function automatic t_window rand_window();
        t_window             w;
        logic signed [H-1:0] base;
        int                  pick;
        base = H'($urandom);
        if ($urandom_range(7) == 0)
            base = $urandom_range(1) ? H_MAX : H_MIN;
        w.center = pick_height(base);
        for (int i = 0; i < 8; i++)
            w.nb[i] = pick_height(base);
        pick = $urandom_range(9);
        if (pick == 0)
            w.mask = 8'h00;
        else if (pick < 5)
            w.mask = 8'hFF;
        else
            w.mask = 8'($urandom);
        w.cvalid = ($urandom_range(9) != 0);
        return w;
    endfunction

    // full-range values, saturating corners, empty mask and invalid center
    task automatic test_extremes();
        set_config(MODE_EQUAL, BLEND_ONE);
        send_window(flat_window(H_MAX, H_MAX, 8'hFF, 1'b1));
        send_window(flat_window(H_MIN, H_MIN, 8'hFF, 1'b1));
        send_window(flat_window(H_MAX, H_MIN, 8'hFF, 1'b1));
        send_window(flat_window(H_MIN, H_MAX, 8'hFF, 1'b1));
        send_window(flat_window(H'(12345), H_MAX, 8'h00, 1'b1));
        send_window(flat_window(H_MIN, H_MAX, 8'hFF, 1'b0));
        send_window(flat_window(H_MAX, H'(-7), 8'hA5, 1'b0));
    endtask

    // one neighbor at a time under the 1-2-1 kernel: corner and edge weights
    task automatic test_kernel();
        t_window w;
        set_config(MODE_GAUSS, BLEND_ONE);
        for (int i = 0; i < 8; i++) begin
            w = flat_window(H'(-1000), H'(0), 8'(1 << i), 1'b1);
            w.nb[i] = H'(5000 + 77 * i);
            send_window(w);
        end
        send_window(flat_window(H'(300), H'(-301), 8'hFF, 1'b1));
    endtask

    // exact halves, both signs, in equal-weight mode
    task automatic test_rounding();
        set_config(MODE_EQUAL, BLEND_ONE);
        send_window(flat_window(H'(0), H'(1), 8'h08, 1'b1));
        send_window(flat_window(H'(0), H'(-1), 8'h08, 1'b1));
        send_window(flat_window(H'(10), H'(13), 8'h01, 1'b1));
        send_window(flat_window(H'(-10), H'(-13), 8'h80, 1'b1));
    endtask

    // no blend, smallest step, just under full, and blend above one saturating
    task automatic test_blend();
        set_config(MODE_GAUSS, '0);
        send_window(rand_window());
        set_config(MODE_EQUAL, BLEND_BITS'(1));
        send_window(flat_window(H'(0), H_MAX, 8'hFF, 1'b1));
        set_config(MODE_EQUAL, BLEND_BITS'(1023));
        send_window(flat_window(H'(100), H'(-2000), 8'h3C, 1'b1));
        set_config(MODE_GAUSS, '1);
        send_window(flat_window(H_MIN, H_MAX, 8'hFF, 1'b1));
        send_window(rand_window());
    endtask

    // random windows over several settings and every pressure phase
    task automatic test_random();
        logic [BLEND_BITS-1:0] blend;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0:       blend = BLEND_ONE;
                1:       blend = '0;
                2:       blend = '1;
                3:       blend = BLEND_BITS'(512);
                default: blend = BLEND_BITS'($urandom_range(1024 + 128));
            endcase
            set_config(logic'(seg % 2), blend);
            idle_pct  = IDLE_PCT[(seg / 2 + seg) % 4];
            stall_pct = STALL_PCT[(seg / 2 + seg) % 4];
            for (int k = 0; k < SEG_BEATS; k++) begin
                // short quiet stretches inside each phase
                if (k == SEG_BEATS / 2) begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end else if (k == SEG_BEATS / 2 + 20) begin
                    idle_pct  = IDLE_PCT[(seg / 2 + seg) % 4];
                    stall_pct = STALL_PCT[(seg / 2 + seg) % 4];
                end
                send_window(rand_window());
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_kernel();
        test_rounding();
        test_blend();
        test_random();
        settle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
rtl/m3hs_pkg.sv
rtl/m3hs_div.sv
rtl/masked_3x3_height_smoother.sv
sim/tb_top.sv
